/* hdl/ddgc_pkg.sv */
// Shared types, widths, codes and the search phase table for the
// diagonal gauge distance unit. No dependencies.
`default_nettype none

package ddgc_pkg;

  localparam int MAX_STEPS = 16384;

  localparam int COORD_W   = 14;
  localparam int RAD_W     = 13;
  localparam int DIST_W    = 22;
  localparam int STAT_W    = 2;
  localparam int OFS_W     = 16;           // coordinate differences
  localparam int U_W       = 23;           // offsets in hundredths
  localparam int M_W       = 22;           // search offset in hundredths
  localparam int P_W       = 24;           // multiplier operand
  localparam int PROD_W    = 2 * P_W;
  localparam int F_W       = PROD_W + 1;
  localparam int STEP_W    = 8;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic signed [U_W-1:0] HUNDRED = U_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARC_RADIUS = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MIXED = 2'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

  typedef enum logic [1:0] {COND_GT, COND_LT, COND_GE} cond_e;
  typedef enum logic [1:0] {REG_ABOVE, REG_BELOW, REG_INSIDE} region_e;
  typedef enum logic [1:0] {MUL_R, MUL_P, MUL_Q} mul_sel_e;
  typedef enum logic [1:0] {RES_LINE, RES_WALK, RES_MIXED} res_sel_e;

  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    cond_e                    cond;
    logic                     last;
  } phase_t;

  typedef struct packed {
    logic                     load;
    logic                     mul_en;
    mul_sel_e                 mul_sel;
    logic                     clr_m;
    logic                     step_en;
    logic signed [STEP_W-1:0] step;
    logic                     out_load;
    res_sel_e                 res_sel;
    logic [STAT_W-1:0]        res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic line_hit;
    logic above;
    logic below;
    logic f_gt;
    logic f_lt;
  } dp_stat_t;

  // Step size, loop condition and last-phase flag of each search phase, per region.
  function automatic phase_t phase_info(region_e rg, logic [1:0] idx);
    phase_t ph;
    ph.step = STEP_W'(100);
    ph.cond = COND_LT;
    ph.last = 1'b1;
    case (rg)
      REG_ABOVE: begin
        case (idx)
          2'd0: begin ph.step = STEP_W'(-100); ph.cond = COND_GT; ph.last = 1'b0; end
          2'd1: begin ph.step = STEP_W'(10);   ph.cond = COND_LT; ph.last = 1'b0; end
          default: begin ph.step = STEP_W'(-1); ph.cond = COND_GT; ph.last = 1'b1; end
        endcase
      end
      REG_BELOW: begin
        case (idx)
          2'd0: begin ph.step = STEP_W'(100);  ph.cond = COND_GE; ph.last = 1'b0; end
          2'd1: begin ph.step = STEP_W'(100);  ph.cond = COND_LT; ph.last = 1'b0; end
          2'd2: begin ph.step = STEP_W'(-10);  ph.cond = COND_GT; ph.last = 1'b0; end
          default: begin ph.step = STEP_W'(1); ph.cond = COND_LT; ph.last = 1'b1; end
        endcase
      end
      default: begin
        ph.step = STEP_W'(100);
        ph.cond = COND_LT;
        ph.last = 1'b1;
      end
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

/* hdl/ddgc_datapath.sv */
// Datapath of the diagonal gauge distance unit: configuration registers,
// operand setup, shared squaring multiplier, offset register and result register.
// Depends on ddgc_pkg.
`default_nettype none

module ddgc_datapath
  import ddgc_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [COORD_W-1:0]          cfg_data_i,
  input  wire logic signed [COORD_W-1:0]   coord_a_i,
  input  wire logic signed [COORD_W-1:0]   coord_b_i,
  input  wire dp_cmd_t                     cmd_i,
  output dp_stat_t                         stat_o,
  output logic signed [DIST_W-1:0]         distance_o,
  output logic [STAT_W-1:0]                status_o
);

  logic signed [COORD_W-1:0] corner_x_q, corner_y_q;
  logic [RAD_W-1:0]          arc_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_x_q   <= '0;
      corner_y_q   <= '0;
      arc_radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CORNER_X:   corner_x_q   <= cfg_data_i;
        CFG_CORNER_Y:   corner_y_q   <= cfg_data_i;
        CFG_ARC_RADIUS: arc_radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand setup from the incoming transaction
  logic signed [OFS_W-1:0] a_x, b_x, kx_x, ky_x, rad_x, cx, cy, dx, dy, ln_src;
  logic                    hline, vline;
  logic signed [U_W-1:0]   u_d, v_d, r100_d, ln_d;

  always_comb begin
    a_x    = OFS_W'(coord_a_i);
    b_x    = OFS_W'(coord_b_i);
    kx_x   = OFS_W'(corner_x_q);
    ky_x   = OFS_W'(corner_y_q);
    rad_x  = $signed({{(OFS_W-RAD_W){1'b0}}, arc_radius_q});
    cx     = kx_x - rad_x;
    cy     = ky_x - rad_x;
    dx     = a_x - kx_x;
    dy     = b_x - ky_x;
    hline  = (a_x - dy) < cx;
    vline  = (b_x - dx) <= cy;
    ln_src = hline ? dy : dx;
    ln_d   = U_W'(ln_src) * HUNDRED;
    u_d    = U_W'(a_x - cx) * HUNDRED;
    v_d    = U_W'(b_x - cy) * HUNDRED;
    r100_d = U_W'(rad_x) * HUNDRED;
  end

  logic signed [U_W-1:0]    u_q, v_q, r100_q;
  logic signed [DIST_W-1:0] line_dist_q;
  logic                     line_hit_q, above_q, below_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_q         <= u_d;
      v_q         <= v_d;
      r100_q      <= r100_d;
      line_dist_q <= DIST_W'(ln_d);
      line_hit_q  <= hline || vline;
      above_q     <= (a_x > cx) && (b_x > cy);
      below_q     <= (a_x < cx) && (b_x < cy);
    end
  end

  logic signed [M_W-1:0] m_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_m) begin
      m_q <= '0;
    end else if (cmd_i.step_en) begin
      m_q <= m_q + M_W'(cmd_i.step);
    end
  end

  // One shared squarer: radius once, then p and q for each offset
  logic signed [P_W-1:0]    op;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] r2_q, pp_q, qq_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_R:   op = P_W'(r100_q);
      MUL_P:   op = P_W'(m_q) + P_W'(u_q);
      MUL_Q:   op = P_W'(m_q) + P_W'(v_q);
      default: op = '0;
    endcase
    prod = op * op;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_R:   r2_q <= prod;
        MUL_P:   pp_q <= prod;
        MUL_Q:   qq_q <= prod;
        default: ;
      endcase
    end
  end

  logic signed [F_W-1:0] f_sum, r2_ext;

  always_comb begin
    f_sum  = F_W'(pp_q) + F_W'(qq_q);
    r2_ext = F_W'(r2_q);
    stat_o.line_hit = line_hit_q;
    stat_o.above    = above_q;
    stat_o.below    = below_q;
    stat_o.f_gt     = f_sum > r2_ext;
    stat_o.f_lt     = f_sum < r2_ext;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= cmd_i.res_status;
      case (cmd_i.res_sel)
        RES_LINE: distance_o <= line_dist_q;
        RES_WALK: distance_o <= DIST_W'(-m_q);
        default:  distance_o <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/ddgc_ctrl.sv */
// Controller of the diagonal gauge distance unit: sequences classification,
// search phases and step counting, and owns both handshakes. Depends on ddgc_pkg.
`default_nettype none

module ddgc_ctrl
  import ddgc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LINE = 3'd1;
  localparam logic [2:0] S_SQP  = 3'd2;
  localparam logic [2:0] S_SQQ  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic              classify_q, classify_d;
  region_e           region_q, region_d;
  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  res_sel_e          res_sel_q, res_sel_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;

  phase_t ph;
  logic   go;

  always_comb begin
    ph = phase_info(region_q, phase_q);
    case (ph.cond)
      COND_GT: go = stat_i.f_gt;
      COND_LT: go = stat_i.f_lt;
      COND_GE: go = !stat_i.f_lt;
      default: go = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    classify_d = classify_q;
    region_d   = region_q;
    phase_d    = phase_q;
    steps_d    = steps_q;
    res_sel_d  = res_sel_q;
    res_stat_d = res_stat_q;
    cmd_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LINE;
        end
      end
      S_LINE: begin
        if (stat_i.line_hit) begin
          res_sel_d  = RES_LINE;
          res_stat_d = ST_OK;
          state_d    = S_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_R;
          cmd_o.clr_m   = 1'b1;
          steps_d       = '0;
          classify_d    = 1'b1;
          state_d       = S_SQP;
        end
      end
      S_SQP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P;
        state_d       = S_SQQ;
      end
      S_SQQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Q;
        state_d       = S_CMP;
      end
      S_CMP: begin
        // The offset is unchanged between phases, so the compare stays valid.
        if (classify_q) begin
          classify_d = 1'b0;
          phase_d    = '0;
          if (!stat_i.f_gt) begin
            region_d = REG_INSIDE;
          end else if (stat_i.above) begin
            region_d = REG_ABOVE;
          end else if (stat_i.below) begin
            region_d = REG_BELOW;
          end else begin
            res_sel_d  = RES_MIXED;
            res_stat_d = ST_MIXED;
            state_d    = S_DONE;
          end
        end else if (!go) begin
          if (ph.last) begin
            res_sel_d  = RES_WALK;
            res_stat_d = ST_OK;
            state_d    = S_DONE;
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end else if (steps_q >= CNT_W'(MAX_STEPS)) begin
          res_sel_d  = RES_WALK;
          res_stat_d = ST_LIMIT;
          state_d    = S_DONE;
        end else begin
          cmd_o.step_en = 1'b1;
          cmd_o.step    = ph.step;
          steps_d       = steps_q + CNT_W'(1);
          state_d       = S_SQP;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.res_sel    = res_sel_q;
          cmd_o.res_status = res_stat_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      classify_q  <= 1'b0;
      region_q    <= REG_ABOVE;
      phase_q     <= '0;
      steps_q     <= '0;
      res_sel_q   <= RES_LINE;
      res_stat_q  <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      classify_q  <= classify_d;
      region_q    <= region_d;
      phase_q     <= phase_d;
      steps_q     <= steps_d;
      res_sel_q   <= res_sel_d;
      res_stat_q  <= res_stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= CNT_W'(MAX_STEPS))
    else $error("step counter passed the limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LINE))
    else $error("accepted transaction did not start the search");

  a_step_only_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_en |-> (state_q == S_CMP && !classify_q))
    else $error("offset stepped outside a search compare");

endmodule

`default_nettype wire

/* hdl/diagonal_distance_to_gauge_curve_unit.sv */
// Diagonal distance to a gauge curve (two straight lines joined by a quarter
// circle), one result per transaction. A point that hits a straight part goes
// from the line check straight to the result. A point on the arc is found by a
// search whose steps each pass the one shared squaring multiplier in turn (p
// squared, q squared, compare); the search stops at the 16384-step limit.
// One transaction is in work at a time; the output register lets the next
// transaction be accepted while a result still waits to be taken. Depends on
// ddgc_pkg, ddgc_ctrl, ddgc_datapath.
`default_nettype none

module diagonal_distance_to_gauge_curve_unit
  import ddgc_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [COORD_W-1:0]        cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [COORD_W-1:0] coord_a_i,
  input  wire logic signed [COORD_W-1:0] coord_b_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [DIST_W-1:0]       distance_o,
  output logic [STAT_W-1:0]              status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ddgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ddgc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coord_a_i  (coord_a_i),
    .coord_b_i  (coord_b_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .distance_o (distance_o),
    .status_o   (status_o)
  );

endmodule

`default_nettype wire
